>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the resampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pgr_pkg.sv
// Shared constants, types and fixed-point helpers of the grid resampler.
package pgr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PTS_W       = ADDR_W + 1;
    localparam int CFG_W       = 11;
    localparam int COEF_W      = 48;
    localparam int AMAG_W      = 45;
    localparam int BMAG_W      = 33;
    localparam int PROD_W      = AMAG_W + BMAG_W;
    localparam int SHQ_W       = PROD_W - 16;
    localparam int DSR_W       = 47;
    localparam int DVD_W       = AMAG_W + 16;
    localparam int DIV_STEPS   = DVD_W;
    localparam int MUL_STEPS   = BMAG_W;
    localparam int CNT_W       = $clog2(DVD_W);
    localparam int WGT_W       = 17;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [63:0]       wide_t;

    localparam coef_t COEF_LIM = 48'sd35184372088831;
    localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        ARITH_DIV,
        ARITH_MULQ,
        ARITH_MULRAW
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
        coef_t     a;
        coef_t     b;
    } arith_req_t;

    typedef struct packed {
        logic  done;
        wide_t res;
    } arith_rsp_t;

    function automatic coef_t clamp_coef(input coef_t v);
        if (v > COEF_LIM) return COEF_LIM;
        if (v < -COEF_LIM) return -COEF_LIM;
        return v;
    endfunction

    function automatic coef_t mag_coef(input coef_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic coef_t ext32(input logic signed [31:0] v);
        return {{(COEF_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

>>> hw/rtl/parabolic_grid_resampler_unit.sv
// Parabolic grid resampler: old-grid store, pointer search and blended-parabola sequencer.
// A load is written while the block is idle. A query walks the search pointer, fetches a window,
// then runs shared-unit ops: a cached parabolic segment evaluates and blends two parabolas,
// a new one first fits its parabolas and weight; a linear end segment takes one multiply (new: a divide first).
// All divides and multiplies run through one shared unit; the grid RAM has one read port.
// Reset (sync, active low) restores search state and table_points; the grid RAM is not cleared.
module parabolic_grid_resampler_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input item beats
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [9:0]                 s_table_index,
    input  logic signed [31:0]         s_position,
    input  logic signed [31:0]         s_sample_value,
    input  logic                       s_last_query,
    // result beats
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_value,
    output logic                       m_last_result,
    // table_points register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pgr_pkg::CFG_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_WIN,
        S_DECIDE,
        S_PD,
        S_PD2,
        S_PCC,
        S_PC1,
        S_WGT,
        S_EF1,
        S_EF2,
        S_EB1,
        S_EB2,
        S_BL1,
        S_BL2,
        S_LDIV,
        S_LMUL,
        S_DONE
    } state_t;

    // grid store
    logic signed [31:0] pos_mem [pgr_pkg::TABLE_DEPTH];
    logic signed [31:0] val_mem [pgr_pkg::TABLE_DEPTH];
    logic signed [31:0] rd_x_reg;
    logic signed [31:0] rd_f_reg;
    logic [pgr_pkg::ADDR_W-1:0] rd_addr;
    logic [pgr_pkg::ADDR_W-1:0] wr_addr;
    logic                       ld_wr;

    // control
    state_t                    state_reg;
    logic                      run_reg;
    logic [pgr_pkg::CFG_W-1:0] tp_reg;
    logic [pgr_pkg::PTS_W-1:0] n_eff;
    logic [pgr_pkg::PTS_W-1:0] n_reg;
    logic [pgr_pkg::PTS_W-1:0] l_reg;
    logic [pgr_pkg::PTS_W-1:0] sp_reg;
    logic [pgr_pkg::PTS_W-1:0] seg_reg;
    logic [2:0]                win_cnt_reg;
    logic                      par_hi_reg;
    logic                      m_valid_reg;

    // datapath
    logic signed [31:0]  x_reg;
    logic                lastq_reg;
    logic signed [31:0]  wx_reg [4];
    logic signed [31:0]  wf_reg [4];
    pgr_pkg::coef_t      d_reg;
    pgr_pkg::coef_t      d2_reg;
    pgr_pkg::coef_t      cc_reg;
    pgr_pkg::coef_t      t_reg;
    pgr_pkg::coef_t      pf_reg;
    pgr_pkg::coef_t      pb_reg;
    pgr_pkg::coef_t      fwd_reg [3];
    pgr_pkg::coef_t      bk_reg [3];
    logic [pgr_pkg::WGT_W-1:0] wgt_reg;
    pgr_pkg::wide_t      p1_reg;
    pgr_pkg::wide_t      res_reg;
    logic signed [31:0]  m_value_reg;
    logic                m_last_reg;

    // shared unit
    pgr_pkg::arith_req_t areq;
    pgr_pkg::arith_rsp_t arsp;
    pgr_pkg::coef_t      ares_c;

    // operand selection
    pgr_pkg::coef_t px0, px1, px2, pv0, pv1, pv2;
    pgr_pkg::coef_t dxf, dxb;
    pgr_pkg::coef_t c1_new;
    pgr_pkg::wide_t blend_sum;
    pgr_pkg::wide_t blend_mag;
    pgr_pkg::wide_t blend_q;
    logic           parab;
    logic           out_free;

    pgr_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .rsp     (arsp)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_last_result = m_last_reg;

    assign ld_wr   = s_valid && s_ready && !s_operation
                  && (int'(s_table_index) < pgr_pkg::TABLE_DEPTH);
    assign wr_addr = pgr_pkg::ADDR_W'(s_table_index);
    assign ares_c  = arsp.res[pgr_pkg::COEF_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    // Clamp the point count to the usable range of the table.
    always_comb begin
        if (int'(tp_reg) < 3) begin
            n_eff = pgr_pkg::PTS_W'(3);
        end else if (int'(tp_reg) > pgr_pkg::TABLE_DEPTH) begin
            n_eff = pgr_pkg::PTS_W'(pgr_pkg::TABLE_DEPTH);
        end else begin
            n_eff = pgr_pkg::PTS_W'(tp_reg);
        end
    end

    // The single RAM read port serves the pointer walk and the window fetch.
    always_comb begin
        case (state_reg)
            S_SRCH_RD: rd_addr = pgr_pkg::ADDR_W'(l_reg - pgr_pkg::PTS_W'(1));
            S_WIN:     rd_addr = pgr_pkg::ADDR_W'(l_reg - pgr_pkg::PTS_W'(3)
                                                  + pgr_pkg::PTS_W'(win_cnt_reg));
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld_wr) begin
            pos_mem[wr_addr] <= s_position;
            val_mem[wr_addr] <= s_sample_value;
        end
        rd_x_reg <= pos_mem[rd_addr];
        rd_f_reg <= val_mem[rd_addr];
    end

    // Window holds points l-3 .. l (zero-based). The backward parabola uses the
    // first three, the forward one the last three.
    always_comb begin
        px0 = pgr_pkg::ext32(par_hi_reg ? wx_reg[1] : wx_reg[0]);
        px1 = pgr_pkg::ext32(par_hi_reg ? wx_reg[2] : wx_reg[1]);
        px2 = pgr_pkg::ext32(par_hi_reg ? wx_reg[3] : wx_reg[2]);
        pv0 = pgr_pkg::ext32(par_hi_reg ? wf_reg[1] : wf_reg[0]);
        pv1 = pgr_pkg::ext32(par_hi_reg ? wf_reg[2] : wf_reg[1]);
        pv2 = pgr_pkg::ext32(par_hi_reg ? wf_reg[3] : wf_reg[2]);
        dxf = pgr_pkg::ext32(x_reg) - pgr_pkg::ext32(wx_reg[2]);
        dxb = pgr_pkg::ext32(x_reg) - pgr_pkg::ext32(wx_reg[1]);
        c1_new = pgr_pkg::clamp_coef(d_reg + ares_c);
        parab  = (l_reg > pgr_pkg::PTS_W'(2)) && (l_reg < n_reg);

        // blend: exact products summed, then truncate toward zero by 2^16
        blend_sum = p1_reg + arsp.res;
        blend_mag = (blend_sum < 0) ? -blend_sum : blend_sum;
        blend_q   = blend_mag >>> 16;
    end

    // Operands for the shared unit, one operation per sequencer state.
    always_comb begin
        areq.start = 1'b0;
        areq.op    = pgr_pkg::ARITH_DIV;
        areq.a     = '0;
        areq.b     = '0;
        case (state_reg)
            S_PD: begin
                areq.start = !run_reg;
                areq.a     = pv1 - pv0;
                areq.b     = px1 - px0;
            end
            S_PD2: begin
                areq.start = !run_reg;
                areq.a     = pv2 - pv1;
                areq.b     = px2 - px1;
            end
            S_PCC: begin
                areq.start = !run_reg;
                areq.a     = d2_reg - d_reg;
                areq.b     = px2 - px0;
            end
            S_PC1: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULQ;
                areq.a     = cc_reg;
                areq.b     = px1 - px0;
            end
            S_WGT: begin
                areq.start = !run_reg && (fwd_reg[2] != '0);
                areq.a     = pgr_pkg::mag_coef(fwd_reg[2]);
                areq.b     = pgr_pkg::mag_coef(fwd_reg[2]) + pgr_pkg::mag_coef(bk_reg[2]);
            end
            S_EF1: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULQ;
                areq.a     = fwd_reg[2];
                areq.b     = dxf;
            end
            S_EF2: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULQ;
                areq.a     = t_reg;
                areq.b     = dxf;
            end
            S_EB1: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULQ;
                areq.a     = bk_reg[2];
                areq.b     = dxb;
            end
            S_EB2: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULQ;
                areq.a     = t_reg;
                areq.b     = dxb;
            end
            S_BL1: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULRAW;
                areq.a     = pf_reg;
                areq.b     = pgr_pkg::COEF_W'(pgr_pkg::ONE_Q16 - wgt_reg);
            end
            S_BL2: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULRAW;
                areq.a     = pb_reg;
                areq.b     = pgr_pkg::COEF_W'(wgt_reg);
            end
            S_LDIV: begin
                areq.start = !run_reg;
                areq.a     = pgr_pkg::ext32(wf_reg[2]) - pgr_pkg::ext32(wf_reg[1]);
                areq.b     = pgr_pkg::ext32(wx_reg[2]) - pgr_pkg::ext32(wx_reg[1]);
            end
            S_LMUL: begin
                areq.start = !run_reg;
                areq.op    = pgr_pkg::ARITH_MULQ;
                areq.a     = fwd_reg[1];
                areq.b     = dxb;
            end
            default: begin
                areq.start = 1'b0;
            end
        endcase
    end

    // Sequencer: state, search registers, coefficient cache and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            run_reg     <= 1'b0;
            tp_reg      <= pgr_pkg::CFG_W'(pgr_pkg::TABLE_DEPTH);
            sp_reg      <= pgr_pkg::PTS_W'(2);
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
            wgt_reg     <= '0;
            for (int k = 0; k < 3; k++) begin
                fwd_reg[k] <= '0;
                bk_reg[k]  <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                tp_reg <= cfg_data;
            end
            // drop the result beat once taken, unless a new one loads this cycle
            if (m_ready && !(state_reg == S_DONE && out_free)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_operation) begin
                        x_reg     <= s_position;
                        lastq_reg <= s_last_query;
                        n_reg     <= n_eff;
                        l_reg     <= sp_reg;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    // past the end: clamp to the last segment
                    if (l_reg > n_reg) begin
                        l_reg       <= n_reg;
                        win_cnt_reg <= '0;
                        state_reg   <= S_WIN;
                    end else begin
                        state_reg <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (x_reg >= rd_x_reg) begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end else begin
                        win_cnt_reg <= '0;
                        state_reg   <= S_WIN;
                    end
                end
                S_WIN: begin
                    if (win_cnt_reg != '0) begin
                        wx_reg[2'(win_cnt_reg - 3'd1)] <= rd_x_reg;
                        wf_reg[2'(win_cnt_reg - 3'd1)] <= rd_f_reg;
                    end
                    win_cnt_reg <= win_cnt_reg + 1'b1;
                    if (win_cnt_reg == 3'd4) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (parab) begin
                        if (l_reg != seg_reg) begin
                            seg_reg <= l_reg;
                            // step by one: the old forward parabola becomes the backward one
                            if (l_reg > pgr_pkg::PTS_W'(3)
                                && l_reg == seg_reg + pgr_pkg::PTS_W'(1)) begin
                                for (int k = 0; k < 3; k++) begin
                                    bk_reg[k] <= fwd_reg[k];
                                end
                                par_hi_reg <= 1'b1;
                            end else begin
                                par_hi_reg <= 1'b0;
                            end
                            state_reg <= S_PD;
                        end else begin
                            state_reg <= S_EF1;
                        end
                    end else begin
                        if (l_reg != seg_reg) begin
                            seg_reg    <= l_reg;
                            fwd_reg[0] <= pgr_pkg::ext32(wf_reg[1]);
                            state_reg  <= S_LDIV;
                        end else begin
                            state_reg <= S_LMUL;
                        end
                    end
                end
                S_WGT: begin
                    if (!run_reg) begin
                        if (fwd_reg[2] == '0) begin
                            wgt_reg   <= '0;
                            state_reg <= S_EF1;
                        end else begin
                            run_reg <= 1'b1;
                        end
                    end else if (arsp.done) begin
                        run_reg   <= 1'b0;
                        wgt_reg   <= arsp.res[pgr_pkg::WGT_W-1:0];
                        state_reg <= S_EF1;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= pgr_pkg::sat32(res_reg);
                        m_last_reg  <= lastq_reg;
                        if (lastq_reg) begin
                            sp_reg  <= pgr_pkg::PTS_W'(2);
                            seg_reg <= '0;
                        end else begin
                            sp_reg <= l_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    // operation states: start the unit, then wait for its done pulse
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (arsp.done) begin
                        run_reg <= 1'b0;
                        case (state_reg)
                            S_PD: begin
                                d_reg     <= ares_c;
                                state_reg <= S_PD2;
                            end
                            S_PD2: begin
                                d2_reg    <= ares_c;
                                state_reg <= S_PCC;
                            end
                            S_PCC: begin
                                cc_reg    <= ares_c;
                                state_reg <= S_PC1;
                            end
                            S_PC1: begin
                                if (par_hi_reg) begin
                                    fwd_reg[0] <= pv1;
                                    fwd_reg[1] <= c1_new;
                                    fwd_reg[2] <= cc_reg;
                                    state_reg  <= S_WGT;
                                end else begin
                                    bk_reg[0]  <= pv1;
                                    bk_reg[1]  <= c1_new;
                                    bk_reg[2]  <= cc_reg;
                                    par_hi_reg <= 1'b1;
                                    state_reg  <= S_PD;
                                end
                            end
                            S_EF1: begin
                                t_reg     <= pgr_pkg::clamp_coef(fwd_reg[1] + ares_c);
                                state_reg <= S_EF2;
                            end
                            S_EF2: begin
                                pf_reg    <= pgr_pkg::clamp_coef(fwd_reg[0] + ares_c);
                                state_reg <= S_EB1;
                            end
                            S_EB1: begin
                                t_reg     <= pgr_pkg::clamp_coef(bk_reg[1] + ares_c);
                                state_reg <= S_EB2;
                            end
                            S_EB2: begin
                                pb_reg    <= pgr_pkg::clamp_coef(bk_reg[0] + ares_c);
                                state_reg <= S_BL1;
                            end
                            S_BL1: begin
                                p1_reg    <= arsp.res;
                                state_reg <= S_BL2;
                            end
                            S_BL2: begin
                                res_reg   <= (blend_sum < 0) ? -blend_q : blend_q;
                                state_reg <= S_DONE;
                            end
                            S_LDIV: begin
                                fwd_reg[1] <= ares_c;
                                state_reg  <= S_LMUL;
                            end
                            S_LMUL: begin
                                res_reg <= pgr_pkg::wide_t'(
                                    pgr_pkg::clamp_coef(fwd_reg[0] + ares_c));
                                state_reg <= S_DONE;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/pgr_arith.sv
// Shared serial divide and multiply unit: one quotient or partial-product bit a cycle.
module pgr_arith (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pgr_pkg::arith_req_t   req,
    output pgr_pkg::arith_rsp_t   rsp
);

    localparam logic [pgr_pkg::DVD_W-1:0] LIM_Q = pgr_pkg::DVD_W'(pgr_pkg::COEF_LIM);
    localparam logic [pgr_pkg::SHQ_W-1:0] LIM_M = pgr_pkg::SHQ_W'(pgr_pkg::COEF_LIM);

    logic                        busy_reg;
    logic                        done_reg;
    pgr_pkg::arith_op_t          op_reg;
    logic [pgr_pkg::CNT_W-1:0]   cnt_reg;
    logic                        neg_reg;
    logic [pgr_pkg::DVD_W-1:0]   quo_reg;
    logic [pgr_pkg::DSR_W-1:0]   rem_reg;
    logic [pgr_pkg::DSR_W-1:0]   dsr_reg;
    logic [pgr_pkg::PROD_W-1:0]  acc_reg;
    logic [pgr_pkg::AMAG_W-1:0]  amag_reg;
    logic [pgr_pkg::BMAG_W-1:0]  bmag_reg;
    pgr_pkg::wide_t              res_reg;

    pgr_pkg::coef_t              num_c;
    pgr_pkg::coef_t              num_mag;
    pgr_pkg::coef_t              a_mag;
    pgr_pkg::coef_t              b_mag;
    logic [pgr_pkg::DSR_W:0]     trial;
    logic [pgr_pkg::DSR_W:0]     diff;
    logic                        fits;
    logic [pgr_pkg::DSR_W-1:0]   rem_next;
    logic [pgr_pkg::DVD_W-1:0]   quo_next;
    logic [pgr_pkg::PROD_W-1:0]  acc_next;
    pgr_pkg::coef_t              q_sat;
    pgr_pkg::coef_t              m_sat;
    pgr_pkg::wide_t              mag_out;

    always_comb begin
        num_c   = pgr_pkg::clamp_coef(req.a);
        num_mag = pgr_pkg::mag_coef(num_c);
        a_mag   = pgr_pkg::mag_coef(req.a);
        b_mag   = pgr_pkg::mag_coef(req.b);

        trial    = {rem_reg, quo_reg[pgr_pkg::DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[pgr_pkg::DSR_W-1:0] : trial[pgr_pkg::DSR_W-1:0];
        quo_next = {quo_reg[pgr_pkg::DVD_W-2:0], fits};

        acc_next = {acc_reg[pgr_pkg::PROD_W-2:0], 1'b0}
                 + (bmag_reg[pgr_pkg::BMAG_W-1] ? pgr_pkg::PROD_W'(amag_reg)
                                               : '0);

        q_sat = (quo_next > LIM_Q) ? pgr_pkg::COEF_LIM : quo_next[pgr_pkg::COEF_W-1:0];
        m_sat = (acc_next[pgr_pkg::PROD_W-1:16] > LIM_M) ? pgr_pkg::COEF_LIM
              : acc_next[pgr_pkg::COEF_W+15:16];

        case (op_reg)
            pgr_pkg::ARITH_DIV:    mag_out = pgr_pkg::wide_t'(q_sat);
            pgr_pkg::ARITH_MULQ:   mag_out = pgr_pkg::wide_t'(m_sat);
            pgr_pkg::ARITH_MULRAW: mag_out = {1'b0, acc_next[62:0]};
            default:               mag_out = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start) begin
                op_reg <= req.op;
                if (req.op == pgr_pkg::ARITH_DIV) begin
                    if (req.b == '0) begin
                        // zero gap: saturate by the sign of the numerator
                        done_reg <= 1'b1;
                        if (num_c > 0) begin
                            res_reg <= pgr_pkg::wide_t'(pgr_pkg::COEF_LIM);
                        end else if (num_c < 0) begin
                            res_reg <= -pgr_pkg::wide_t'(pgr_pkg::COEF_LIM);
                        end else begin
                            res_reg <= '0;
                        end
                    end else begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= pgr_pkg::CNT_W'(pgr_pkg::DIV_STEPS - 1);
                        quo_reg  <= {num_mag[pgr_pkg::AMAG_W-1:0], 16'b0};
                        rem_reg  <= '0;
                        dsr_reg  <= b_mag[pgr_pkg::DSR_W-1:0];
                        neg_reg  <= num_c[pgr_pkg::COEF_W-1] ^ req.b[pgr_pkg::COEF_W-1];
                    end
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= pgr_pkg::CNT_W'(pgr_pkg::MUL_STEPS - 1);
                    acc_reg  <= '0;
                    amag_reg <= a_mag[pgr_pkg::AMAG_W-1:0];
                    bmag_reg <= b_mag[pgr_pkg::BMAG_W-1:0];
                    neg_reg  <= req.a[pgr_pkg::COEF_W-1] ^ req.b[pgr_pkg::COEF_W-1];
                end
            end else if (busy_reg) begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                acc_reg  <= acc_next;
                bmag_reg <= {bmag_reg[pgr_pkg::BMAG_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= neg_reg ? -mag_out : mag_out;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

>>> hw/rtl/pgr_checker.sv
// Port-level checker of the grid resampler and its bind to the top level.
`include "assert_macros.svh"

module pgr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_operation,
    input logic [9:0]                 s_table_index,
    input logic signed [31:0]         s_position,
    input logic signed [31:0]         s_sample_value,
    input logic                       s_last_query,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [31:0]         m_value,
    input logic                       m_last_result,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [pgr_pkg::CFG_W-1:0]  cfg_data
);

    // a stalled result beat holds
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                m_valid && $stable(m_value) && $stable(m_last_result), "result beat changed")

    // a query beat occupies the block
    `ASSERT_NXT(a_query_busy, aclk, aresetn, s_valid && s_ready && s_operation,
                !s_ready, "ready after query beat")

    // a load beat completes at once
    `ASSERT_NXT(a_load_quick, aclk, aresetn, s_valid && s_ready && !s_operation,
                s_ready, "not ready after load beat")

    // a new result appears only from a query in progress
    `ASSERT_IMP(a_result_src, aclk, aresetn, $rose(m_valid),
                !$past(s_ready), "result without query")

endmodule

bind parabolic_grid_resampler_unit pgr_checker u_pgr_checker (.*);

>>> verif/parabolic_grid_resampler_unit_checker.sv
// Checker of the grid resampler: predicts every result beat and compares it.
`timescale 1ns / 100ps
module parabolic_grid_resampler_unit_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_operation,
    input  logic [9:0]         s_table_index,
    input  logic signed [31:0] s_position,
    input  logic signed [31:0] s_sample_value,
    input  logic               s_last_query,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_value,
    input  logic               m_last_result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [pgr_pkg::CFG_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);
    localparam longint SAT_LIM = 64'sd35184372088831;
    localparam longint UNIT    = 64'sd65536;
    localparam int     DEPTH   = pgr_pkg::TABLE_DEPTH;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } resample_beat_t;

    resample_beat_t     expected_values[$];
    logic signed [31:0] grid_pos[DEPTH];
    logic signed [31:0] grid_val[DEPTH];
    int                 points_reg;
    int                 walk_ptr;
    int                 cached_seg;
    longint             fwd[3];
    longint             bwd[3];
    longint             weight;

    function automatic longint sat_coef(longint v);
        if (v > SAT_LIM) return SAT_LIM;
        if (v < -SAT_LIM) return -SAT_LIM;
        return v;
    endfunction

    function automatic longint scaled_div(longint num, longint den);
        num = sat_coef(num);
        if (den == 0) begin
            if (num > 0) return SAT_LIM;
            if (num < 0) return -SAT_LIM;
            return 0;
        end
        return sat_coef((num * UNIT) / den);
    endfunction

    // magnitude product shifted down 16 bits, truncated and saturated
    function automatic longint scaled_mul(longint a, longint b);
        logic          neg;
        logic [63:0]   ua;
        logic [63:0]   ub;
        logic [127:0]  prod;
        longint        r;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        if ((prod >> 16) > 128'(SAT_LIM)) r = SAT_LIM;
        else r = longint'(prod[79:16]);
        return neg ? -r : r;
    endfunction

    function automatic longint gp(int i);
        return longint'(grid_pos[i]);
    endfunction

    function automatic longint gv(int i);
        return longint'(grid_val[i]);
    endfunction

    // parabola through points i, i+1, i+2 centered on i+1
    function automatic void fit_parabola(int i, output longint c0, output longint c1,
                                         output longint c2);
        longint d1;
        longint d2;
        d1 = scaled_div(gv(i + 1) - gv(i), gp(i + 1) - gp(i));
        d2 = scaled_div(gv(i + 2) - gv(i + 1), gp(i + 2) - gp(i + 1));
        c2 = scaled_div(d2 - d1, gp(i + 2) - gp(i));
        c1 = sat_coef(d1 + scaled_mul(c2, gp(i + 1) - gp(i)));
        c0 = gv(i + 1);
    endfunction

    function automatic longint eval_parabola(longint c0, longint c1, longint c2, longint dx);
        longint t;
        t = sat_coef(c1 + scaled_mul(c2, dx));
        return sat_coef(c0 + scaled_mul(t, dx));
    endfunction

    function automatic logic signed [31:0] resample_query(logic signed [31:0] pos);
        int     n;
        int     l;
        longint x;
        longint res;
        longint pf;
        longint pb;
        longint af;
        longint ab;
        n = points_reg;
        if (n < 3) n = 3;
        if (n > DEPTH) n = DEPTH;
        x = longint'(pos);
        l = walk_ptr;
        while (l <= n && x >= gp(l - 1)) l++;
        if (l > n) l = n;
        if (l > 2 && l < n) begin
            if (l != cached_seg) begin
                if (l > 3 && l == cached_seg + 1) bwd = fwd;
                else fit_parabola(l - 3, bwd[0], bwd[1], bwd[2]);
                fit_parabola(l - 2, fwd[0], fwd[1], fwd[2]);
                weight = 0;
                if (fwd[2] != 0) begin
                    af = (fwd[2] < 0) ? -fwd[2] : fwd[2];
                    ab = (bwd[2] < 0) ? -bwd[2] : bwd[2];
                    weight = (af * UNIT) / (af + ab);
                end
                cached_seg = l;
            end
            pf  = eval_parabola(fwd[0], fwd[1], fwd[2], x - gp(l - 1));
            pb  = eval_parabola(bwd[0], bwd[1], bwd[2], x - gp(l - 2));
            res = ((UNIT - weight) * pf + weight * pb) / UNIT;
        end else begin
            if (l != cached_seg) begin
                cached_seg = l;
                fwd[0] = gv(l - 2);
                fwd[1] = scaled_div(gv(l - 1) - gv(l - 2), gp(l - 1) - gp(l - 2));
            end
            res = sat_coef(fwd[0] + scaled_mul(fwd[1], x - gp(l - 2)));
        end
        walk_ptr = l;
        if (res > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (res < -64'sd2147483648) return 32'sh80000000;
        return res[31:0];
    endfunction

    always @(posedge aclk) begin
        resample_beat_t want;
        if (!aresetn) begin
            expected_values.delete();
            fail_count = 0;
            points_reg = DEPTH;
            walk_ptr   = 2;
            cached_seg = 0;
            fwd        = '{0, 0, 0};
            bwd        = '{0, 0, 0};
            weight     = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    $error("unexpected result beat: value %0d last %0b", m_value,
                           m_last_result);
                    fail_count++;
                end else begin
                    want = expected_values.pop_front();
                    if (m_value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, m_value);
                        fail_count++;
                    end
                    if (m_last_result !== want.last) begin
                        $error("last_result: expected %0b, actual %0b", want.last,
                               m_last_result);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) points_reg = int'(cfg_data);
            if (s_valid && s_ready) begin
                if (!s_operation) begin
                    grid_pos[s_table_index] = s_position;
                    grid_val[s_table_index] = s_sample_value;
                end else begin
                    want.value = resample_query(s_position);
                    want.last  = s_last_query;
                    expected_values.push_back(want);
                    // end of run: restart the walk
                    if (s_last_query) begin
                        walk_ptr   = 2;
                        cached_seg = 0;
                    end
                end
            end
        end
        pending = expected_values.size();
    end
endmodule

>>> verif/parabolic_grid_resampler_unit_tb.sv
// Stimulus and verdict for the parabolic grid resampler.
`timescale 1ns / 100ps
module parabolic_grid_resampler_unit_tb;

    localparam int LOAD = 0;
    localparam int QUERY = 1;
    localparam int ITEM_TARGET = 1100;
    // loads give no result beat, so allow the block to settle before a register write
    localparam int SETTLE_CYCLES = 60;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = 1'b0;
    logic [9:0]         s_table_index = '0;
    logic signed [31:0] s_position = '0;
    logic signed [31:0] s_sample_value = '0;
    logic               s_last_query = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_value;
    logic               m_last_result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [pgr_pkg::CFG_W-1:0] cfg_data = '0;
    int                 fail_count;
    int                 pending;

    // no random idling on either side while set
    logic               steady = 1'b0;
    int                 items_sent = 0;
    longint             grid_lo;
    longint             grid_hi;

    parabolic_grid_resampler_unit i_dut (.*);

    parabolic_grid_resampler_unit_checker i_checker (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver: stall at random, with a chance of 6 in 100, unless the steady stretch is on
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 6);
    end

    // Drive one beat and hold it until accepted. An occasional gap drops valid
    // first; valid never toggles within one time step.
    task automatic send_beat(int op, int idx, longint pos, longint val, bit last);
        if (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op[0];
        s_table_index  <= idx[9:0];
        s_position     <= pos[31:0];
        s_sample_value <= val[31:0];
        s_last_query   <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold off the sender until every result is back, then let the block settle.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_points(int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[pgr_pkg::CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Load an ascending grid; now and then repeat a position to get a zero gap.
    task automatic load_sorted_grid(int cnt, bit wide_values);
        longint p;
        longint v;
        p = longint'($urandom_range(1 << 24)) - (1 << 23);
        grid_lo = p;
        for (int i = 0; i < cnt; i++) begin
            if (wide_values || $urandom_range(19) == 0)
                v = longint'(signed'($urandom()));
            else
                v = longint'($urandom_range(1 << 22)) - (1 << 21);
            send_beat(LOAD, i, p, v, 1'b0);
            grid_hi = p;
            if ($urandom_range(15) != 0) p += $urandom_range(1, 1 << 18);
        end
    endtask

    // One run of ascending queries that starts below the grid.
    task automatic query_run(int cnt, int n_used);
        longint x;
        longint stride;
        stride = (grid_hi - grid_lo) / cnt + 1;
        x = grid_lo - longint'($urandom_range(1 << 16));
        for (int k = 0; k < cnt; k++) begin
            // an occasional load in the middle of a run
            if ($urandom_range(29) == 0)
                send_beat(LOAD, $urandom_range(n_used - 1), x,
                          longint'($urandom_range(1 << 20)), 1'b1);
            send_beat(QUERY, $urandom_range(1023), x, longint'(signed'($urandom())),
                      k == cnt - 1);
            x += $urandom_range(0, 2 * stride);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
        end
    endtask

    // Optionally a broken grid, then out-of-order queries with random fields.
    task automatic noise_phase(int n_used, bit reload);
        if (reload)
            for (int i = 0; i < n_used; i++)
                send_beat(LOAD, i, longint'(signed'($urandom())),
                          longint'(signed'($urandom())), $urandom_range(1));
        repeat ($urandom_range(3, 8))
            send_beat(QUERY, $urandom_range(1023), longint'(signed'($urandom())),
                      longint'(signed'($urandom())), $urandom_range(3) == 0);
        send_beat(QUERY, 0, longint'(signed'($urandom())), 0, 1'b1);
    endtask

    initial begin
        int n;
        int v;
        int phase;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full table under the reset point count; every entry is written from here on
        load_sorted_grid(pgr_pkg::TABLE_DEPTH, 1'b0);
        query_run(40, pgr_pkg::TABLE_DEPTH);
        drain();

        // directed: three points (count below minimum), extreme values and positions
        write_points(0);
        send_beat(LOAD, 0, -100000, 32'sh7FFFFFFF, 1'b0);
        send_beat(LOAD, 1, 0, 32'sh80000000, 1'b0);
        send_beat(LOAD, 2, 65536, 0, 1'b0);
        send_beat(QUERY, 0, 64'sh80000000 - 64'sh100000000, 0, 1'b0);
        send_beat(QUERY, 0, -100000, 0, 1'b0);
        send_beat(QUERY, 0, 30000, 0, 1'b0);
        send_beat(QUERY, 0, 2147483647, 0, 1'b1);

        // directed: four points with zero gaps, parabolic interior segment
        write_points(4);
        send_beat(LOAD, 0, 0, 1000, 1'b0);
        send_beat(LOAD, 1, 0, 5000, 1'b0);
        send_beat(LOAD, 2, 131072, -7000, 1'b0);
        send_beat(LOAD, 3, 131072, 9000, 1'b0);
        send_beat(QUERY, 0, -5, 0, 1'b0);
        send_beat(QUERY, 0, 0, 0, 1'b0);
        send_beat(QUERY, 0, 65536, 0, 1'b0);
        send_beat(QUERY, 0, 131072, 0, 1'b0);
        send_beat(QUERY, 0, 200000, 0, 1'b1);

        // directed: remaining out-of-range counts and the largest register value
        write_points(1);
        send_beat(QUERY, 0, 10, 0, 1'b1);
        write_points(2);
        send_beat(QUERY, 0, 70000, 0, 1'b1);
        write_points(2047);
        send_beat(QUERY, 0, 0, 0, 1'b0);
        send_beat(QUERY, 0, 2147483647, 0, 1'b1);

        // random phases; one stretch runs with no idling on either side
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            steady <= (phase >= 4 && phase < 9);
            if ($urandom_range(19) == 0) begin
                v = $urandom_range(25, 2047);
                write_points(v);
                noise_phase(0, 1'b0);
            end else begin
                n = $urandom_range(3, 24);
                v = n;
                if ($urandom_range(9) == 0) v = $urandom_range(2);
                if (v < 3) n = 3;
                write_points(v);
                if ($urandom_range(99) < 85) begin
                    load_sorted_grid(n, $urandom_range(5) == 0);
                    repeat ($urandom_range(1, 3)) query_run($urandom_range(2, 12), n);
                end else begin
                    noise_phase(n, 1'b1);
                end
            end
            phase++;
        end

        // wait for the last results, then settle
        drain();
        if (fail_count == 0 && pending == 0)
            $display("parabolic_grid_resampler_unit_tb OK");
        else
            $display("parabolic_grid_resampler_unit_tb NOT OK");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #80_000_000;
        $display("parabolic_grid_resampler_unit_tb NOT OK");
        $finish;
    end
endmodule
